[hdl/battery_voltage_to_charge_level_macros.svh]
// Assertion macros for the battery charge level block
`ifndef BATTERY_VOLTAGE_TO_CHARGE_LEVEL_MACROS_SVH
`define BATTERY_VOLTAGE_TO_CHARGE_LEVEL_MACROS_SVH

// clocked assertion, off during reset
`define BVCL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, checked during reset too
`define BVCL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/bvcl_pkg.sv]
// Package: constants, discharge curve table and pipeline types
`timescale 1ns / 1ps
package bvcl_pkg;

    localparam int CURVE_POINTS = 10;
    localparam int CURVE_COUNT  = 5;
    localparam int MV_W         = 14;
    localparam int CUR_W        = 16;
    localparam int CAP_W        = 16;
    localparam int CHG_W        = 10;
    localparam int CURVE_W      = 3;
    localparam int IDX_W        = $clog2(CURVE_POINTS);
    localparam int SEG_TENTHS   = 100;
    localparam int FULL_CHARGE  = 1000;
    localparam int QUO_W        = $clog2(SEG_TENTHS);
    localparam int REM_W        = MV_W + QUO_W;
    localparam int PROD_W       = CUR_W + 5;
    localparam int CAP_RESET    = 22500;

    typedef logic [MV_W-1:0]    mv_t;
    typedef logic [CURVE_W-1:0] curve_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CHG_W-1:0]   chg_t;

    localparam mv_t CURVE_MV [CURVE_COUNT][CURVE_POINTS] = '{
        '{14'd9500,  14'd10000, 14'd10400, 14'd10700, 14'd11000,
          14'd11200, 14'd11300, 14'd11500, 14'd11600, 14'd11700},
        '{14'd10200, 14'd10600, 14'd10900, 14'd11200, 14'd11400,
          14'd11600, 14'd11700, 14'd11800, 14'd11900, 14'd12000},
        '{14'd11000, 14'd11300, 14'd11500, 14'd11700, 14'd11900,
          14'd12000, 14'd12200, 14'd12200, 14'd12300, 14'd12400},
        '{14'd11500, 14'd11700, 14'd11900, 14'd12100, 14'd12200,
          14'd12300, 14'd12400, 14'd12500, 14'd12600, 14'd12700},
        '{14'd11700, 14'd11900, 14'd12100, 14'd12300, 14'd12400,
          14'd12500, 14'd12550, 14'd12600, 14'd12650, 14'd12700}
    };

    localparam curve_t CURVE_HEAVY = 3'd0;
    localparam curve_t CURVE_HIGH  = 3'd1;
    localparam curve_t CURVE_MID   = 3'd2;
    localparam curve_t CURVE_LOW   = 3'd3;
    localparam curve_t CURVE_LIGHT = 3'd4;

    typedef struct packed {
        curve_t            curve;
        chg_t              base;
        logic [REM_W-1:0]  rem;
        mv_t               den;
        logic [QUO_W-1:0]  quo;
    } div_t;

endpackage

[hdl/bvcl_curve_sel.sv]
// Curve selection stage: load current against capacity thresholds
`timescale 1ns / 1ps
module bvcl_curve_sel (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  bvcl_pkg::mv_t        voltage_mv,
    input  logic [15:0]          current_ma,
    input  logic [15:0]          capacity,
    output logic                 sel_valid,
    output bvcl_pkg::mv_t        sel_voltage,
    output bvcl_pkg::curve_t     sel_curve
);
    import bvcl_pkg::*;

    logic              valid_reg;
    mv_t               voltage_reg;
    curve_t            curve_reg;
    curve_t            curve_next;
    logic [PROD_W-1:0] cap_ext;

    always_comb
    begin
        cap_ext = PROD_W'(capacity);
        if (PROD_W'(current_ma) * PROD_W'(3) > cap_ext)
            curve_next = CURVE_HEAVY;
        else if (PROD_W'(current_ma) * PROD_W'(5) > cap_ext)
            curve_next = CURVE_HIGH;
        else if (PROD_W'(current_ma) * PROD_W'(10) > cap_ext)
            curve_next = CURVE_MID;
        else if (PROD_W'(current_ma) * PROD_W'(20) > cap_ext)
            curve_next = CURVE_LOW;
        else
            curve_next = CURVE_LIGHT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            voltage_reg <= voltage_mv;
            curve_reg   <= curve_next;
        end
    end

    assign sel_valid   = valid_reg;
    assign sel_voltage = voltage_reg;
    assign sel_curve   = curve_reg;
endmodule

[hdl/bvcl_segment.sv]
// Segment search and divider operand setup, two stages
`timescale 1ns / 1ps
module bvcl_segment (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              sel_valid,
    input  bvcl_pkg::mv_t     sel_voltage,
    input  bvcl_pkg::curve_t  sel_curve,
    output logic              seg_valid,
    output bvcl_pkg::div_t    seg_data
);
    import bvcl_pkg::*;

    // stage A: segment index
    logic   a_valid_reg;
    curve_t a_curve_reg;
    mv_t    a_voltage_reg;
    idx_t   a_k_reg;
    idx_t   a_k_next;
    logic   a_below_reg;
    logic   a_full_reg;

    // stage B: operands
    logic   b_valid_reg;
    div_t   b_data_reg;
    div_t   b_data_next;
    mv_t    lo;
    mv_t    hi;

    always_comb
    begin
        a_k_next = '0;
        for (int i = 1; i < CURVE_POINTS - 1; i++)
        begin
            if (sel_voltage >= CURVE_MV[sel_curve][i])
                a_k_next = a_k_next + idx_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= sel_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_curve_reg   <= sel_curve;
            a_voltage_reg <= sel_voltage;
            a_k_reg       <= a_k_next;
            a_below_reg   <= sel_voltage < CURVE_MV[sel_curve][0];
            a_full_reg    <= sel_voltage >= CURVE_MV[sel_curve][CURVE_POINTS-1];
            b_data_reg    <= b_data_next;
        end
    end

    always_comb
    begin
        lo = CURVE_MV[a_curve_reg][a_k_reg];
        hi = CURVE_MV[a_curve_reg][a_k_reg + idx_t'(1)];
        b_data_next.curve = a_curve_reg;
        b_data_next.quo   = '0;
        if (a_below_reg)
        begin
            b_data_next.base = '0;
            b_data_next.rem  = '0;
            b_data_next.den  = mv_t'(1);
        end
        else if (a_full_reg)
        begin
            b_data_next.base = chg_t'(FULL_CHARGE);
            b_data_next.rem  = '0;
            b_data_next.den  = mv_t'(1);
        end
        else
        begin
            b_data_next.base = chg_t'(a_k_reg) * chg_t'(SEG_TENTHS);
            b_data_next.rem  = REM_W'(a_voltage_reg - lo) * REM_W'(SEG_TENTHS);
            b_data_next.den  = hi - lo;
        end
    end

    assign seg_valid = b_valid_reg;
    assign seg_data  = b_data_reg;
endmodule

[hdl/bvcl_div.sv]
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module bvcl_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            seg_valid,
    input  bvcl_pkg::div_t  seg_data,
    output logic            div_valid,
    output bvcl_pkg::div_t  div_data
);
    import bvcl_pkg::*;

    logic valid_reg [QUO_W];
    div_t st_reg    [QUO_W];

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_stage
        localparam int B = QUO_W - 1 - j;
        logic             src_valid;
        div_t             src;
        div_t             st_next;
        logic [REM_W-1:0] trial;

        if (j == 0)
        begin : g_first
            assign src_valid = seg_valid;
            assign src       = seg_data;
        end
        else
        begin : g_rest
            assign src_valid = valid_reg[j-1];
            assign src       = st_reg[j-1];
        end

        always_comb
        begin
            trial   = REM_W'(src.den) << B;
            st_next = src;
            if (src.rem >= trial)
            begin
                st_next.rem    = src.rem - trial;
                st_next.quo[B] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else if (en)
                valid_reg[j] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[j] <= st_next;
        end
    end

    assign div_valid = valid_reg[QUO_W-1];
    assign div_data  = st_reg[QUO_W-1];
endmodule

[hdl/battery_voltage_to_charge_level.sv]
// Top level: battery voltage to charge level pipeline
//
//  channel | signals                                         | transfer
//  --------+-------------------------------------------------+----------------
//  in      | in_valid, in_ready, voltage_mv, current_ma      | valid & ready
//  out     | out_valid, out_ready, charge_tenths, curve_used | valid & ready
//  cfg     | cfg_we, cfg_wdata (capacity_mah)                | cfg_we, no wait
//
// One item per cycle unless the output is held; stages: curve select, segment search,
// operand setup, 7 divider stages (one quotient bit each), output add.
// Reset clears all valid bits; capacity_mah resets to 22500.
// A held output stalls the whole pipeline; in_ready = !out_valid | out_ready.
`timescale 1ns / 1ps
module battery_voltage_to_charge_level (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [13:0]  voltage_mv,
    input  logic [15:0]  current_ma,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [9:0]   charge_tenths,
    output logic [2:0]   curve_used,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata
);
    import bvcl_pkg::*;

    logic [CAP_W-1:0] capacity_reg;
    logic             en;
    logic             sel_valid;
    mv_t              sel_voltage;
    curve_t           sel_curve;
    logic             seg_valid;
    div_t             seg_data;
    logic             div_valid;
    div_t             div_data;
    logic             out_valid_reg;
    chg_t             charge_reg;
    curve_t           curve_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAP_W'(CAP_RESET);
        else if (cfg_we)
            capacity_reg <= cfg_wdata;
    end

    bvcl_curve_sel u_curve_sel (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (in_valid),
        .voltage_mv  (voltage_mv),
        .current_ma  (current_ma),
        .capacity    (capacity_reg),
        .sel_valid   (sel_valid),
        .sel_voltage (sel_voltage),
        .sel_curve   (sel_curve)
    );

    bvcl_segment u_segment (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .sel_valid   (sel_valid),
        .sel_voltage (sel_voltage),
        .sel_curve   (sel_curve),
        .seg_valid   (seg_valid),
        .seg_data    (seg_data)
    );

    bvcl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .seg_valid (seg_valid),
        .seg_data  (seg_data),
        .div_valid (div_valid),
        .div_data  (div_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            charge_reg <= div_data.base + chg_t'(div_data.quo);
            curve_reg  <= div_data.curve;
        end
    end

    assign out_valid     = out_valid_reg;
    assign charge_tenths = charge_reg;
    assign curve_used    = curve_reg;
endmodule

[hdl/bvcl_checker.sv]
// Port-level checker for the charge level block, with its bind
`timescale 1ns / 1ps
`include "battery_voltage_to_charge_level_macros.svh"
module bvcl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [9:0]  charge_tenths,
    input logic [2:0]  curve_used
);
    import bvcl_pkg::*;

    `BVCL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(charge_tenths) && $stable(curve_used), "stalled item changed")
    `BVCL_ASSERT_ALWAYS(a_ready_rule, in_ready == (!out_valid || out_ready), "input ready does not follow output stall")
    `BVCL_ASSERT(a_charge_range, out_valid |-> charge_tenths <= 10'(FULL_CHARGE), "charge above full")
    `BVCL_ASSERT(a_curve_range, out_valid |-> curve_used <= CURVE_LIGHT, "curve index out of range")
endmodule

bind battery_voltage_to_charge_level bvcl_checker u_bvcl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .charge_tenths (charge_tenths),
    .curve_used    (curve_used)
);
